// ===== sv/smpg_pkg.sv =====
// ----------------------------------------------------------------------------
// smpg_pkg: shared types and constants of the stepper move pulse generator
// Item layouts, command and event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package smpg_pkg;

  localparam int POS_BITS    = 24;
  localparam int PERIOD_BITS = 15;
  localparam int RAMP_BITS   = 16;
  localparam int PULSE_BITS  = POS_BITS + 1;
  localparam int CMD_BITS    = 3;
  localparam int EVENT_BITS  = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  typedef logic signed [POS_BITS-1:0] pos_t;
  typedef logic signed [POS_BITS:0]   pos_wide_t;
  typedef logic [PERIOD_BITS-1:0]     period_t;
  typedef logic [RAMP_BITS-1:0]       ramp_t;
  typedef logic [PULSE_BITS-1:0]      pulse_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK    = 3'd0,
    CMD_MOVE    = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_HOME    = 3'd3,
    CMD_SET_MAX = 3'd4
  } cmd_e;

  typedef enum logic [EVENT_BITS-1:0] {
    EV_NONE   = 2'd0,
    EV_DONE   = 2'd1,
    EV_REJECT = 2'd2
  } event_e;

  localparam logic [CFG_IDX_BITS-1:0] REG_START_PERIOD  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_PERIOD    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_INTERVAL = 2'd2;

  localparam period_t START_PERIOD_RESET  = PERIOD_BITS'(1000);
  localparam period_t MIN_PERIOD_RESET    = PERIOD_BITS'(200);
  localparam ramp_t   RAMP_INTERVAL_RESET = RAMP_BITS'(10);

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    pos_t                value;
  } in_item_t;

  typedef struct packed {
    logic                  step_level;
    logic                  dir_level;
    logic                  moving;
    pos_t                  position;
    pos_t                  max_position;
    logic [EVENT_BITS-1:0] event_res;
  } out_item_t;

  typedef struct packed {
    period_t start_period;
    period_t min_period;
    ramp_t   ramp_interval;
  } cfg_t;

  // Clamp a one-bit-wider sum back into the position range.
  function automatic pos_t sat_pos(input pos_wide_t v);
    pos_t r;
    if (v[POS_BITS] != v[POS_BITS-1]) begin
      r = v[POS_BITS] ? {1'b1, {(POS_BITS-1){1'b0}}} : {1'b0, {(POS_BITS-1){1'b1}}};
    end else begin
      r = v[POS_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/smpg_cfg.sv =====
// ----------------------------------------------------------------------------
// smpg_cfg: ramp configuration registers
// Holds start period, minimum period and ramp interval; plain indexed writes.
// ----------------------------------------------------------------------------
module smpg_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [smpg_pkg::CFG_IDX_BITS-1:0]   wr_index,
  input  logic [smpg_pkg::CFG_DATA_BITS-1:0]  wr_data,
  output smpg_pkg::cfg_t                      cfg
);
  import smpg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_period  <= START_PERIOD_RESET;
      cfg.min_period    <= MIN_PERIOD_RESET;
      cfg.ramp_interval <= RAMP_INTERVAL_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_START_PERIOD:  cfg.start_period  <= wr_data[PERIOD_BITS-1:0];
        REG_MIN_PERIOD:    cfg.min_period    <= wr_data[PERIOD_BITS-1:0];
        REG_RAMP_INTERVAL: cfg.ramp_interval <= wr_data[RAMP_BITS-1:0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

endmodule

// ===== sv/smpg_core.sv =====
// ----------------------------------------------------------------------------
// smpg_core: move state and single-pass item update
// Keeps position, ramp and pulse timing state and computes one result per item.
// ----------------------------------------------------------------------------
module smpg_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  smpg_pkg::in_item_t  item,
  input  smpg_pkg::cfg_t      cfg,
  output smpg_pkg::out_item_t result
);
  import smpg_pkg::*;

  pos_t    position, position_next;
  pos_t    max_position, max_position_next;
  logic    moving, moving_next;
  logic    direction, direction_next;
  pulse_t  pulses_left, pulses_left_next;
  period_t half_period, half_period_next;
  ramp_t   ramp_count, ramp_count_next;
  logic    high_phase, high_phase_next;
  period_t time_left, time_left_next;
  logic [EVENT_BITS-1:0] event_code;

  // Values used by the commands, from the current state, the item and the config.
  pos_wide_t val_w, pos_w, delta;
  pulse_t    delta_mag;
  logic      reject;
  period_t   hp_start;
  logic      ramp_hold, ramp_dec;
  ramp_t     rc_inc;
  period_t   hp_ramp;
  ramp_t     rc_ramp;
  pos_t      pos_step;
  pulse_t    pl_dec;

  always_comb begin
    val_w     = {item.value[POS_BITS-1], item.value};
    pos_w     = {position[POS_BITS-1], position};
    delta     = val_w - pos_w;
    delta_mag = delta[POS_BITS] ? pulse_t'(-delta) : pulse_t'(delta);
    reject    = item.value[POS_BITS-1] || (item.value > max_position);
    hp_start  = (cfg.start_period == '0) ? period_t'(1) : cfg.start_period;

    // The ramp stands still at the minimum, and never goes below one.
    ramp_hold = (half_period <= cfg.min_period) || (half_period <= period_t'(1));
    rc_inc    = ramp_count + ramp_t'(1);
    ramp_dec  = !ramp_hold && !(rc_inc < cfg.ramp_interval);
    hp_ramp   = ramp_dec ? half_period - period_t'(1) : half_period;
    rc_ramp   = ramp_hold ? ramp_count : (ramp_dec ? '0 : rc_inc);

    pos_step = sat_pos(pos_w + (direction ? pos_wide_t'(1) : pos_wide_t'(-1)));
    pl_dec   = pulses_left - pulse_t'(1);
  end

  always_comb begin
    position_next     = position;
    max_position_next = max_position;
    moving_next       = moving;
    direction_next    = direction;
    pulses_left_next  = pulses_left;
    half_period_next  = half_period;
    ramp_count_next   = ramp_count;
    high_phase_next   = high_phase;
    time_left_next    = time_left;
    event_code        = EV_NONE;

    unique case (item.cmd)
      CMD_TICK: begin
        if (moving && time_left == '0) begin
          if (!high_phase) begin
            // End of the low time: ramp, raise the pin, count the step.
            half_period_next = hp_ramp;
            ramp_count_next  = rc_ramp;
            high_phase_next  = 1'b1;
            time_left_next   = hp_ramp;
            position_next    = pos_step;
          end else if (pl_dec == '0) begin
            moving_next      = 1'b0;
            high_phase_next  = 1'b0;
            time_left_next   = '0;
            pulses_left_next = '0;
            half_period_next = hp_start;
            ramp_count_next  = '0;
            event_code       = EV_DONE;
          end else begin
            pulses_left_next = pl_dec;
            high_phase_next  = 1'b0;
            time_left_next   = half_period;
          end
        end
        if (moving_next && time_left_next != '0) begin
          time_left_next = time_left_next - period_t'(1);
        end
      end
      CMD_MOVE: begin
        if (reject) begin
          event_code = EV_REJECT;
        end else begin
          direction_next   = !delta[POS_BITS];
          half_period_next = hp_start;
          ramp_count_next  = '0;
          high_phase_next  = 1'b0;
          if (delta == '0) begin
            moving_next      = 1'b0;
            time_left_next   = '0;
            pulses_left_next = '0;
            event_code       = EV_DONE;
          end else begin
            moving_next      = 1'b1;
            pulses_left_next = delta_mag;
            time_left_next   = hp_start;
          end
        end
      end
      CMD_STOP: begin
        moving_next      = 1'b0;
        high_phase_next  = 1'b0;
        time_left_next   = '0;
        pulses_left_next = '0;
        half_period_next = hp_start;
        ramp_count_next  = '0;
      end
      CMD_HOME: begin
        if (!moving) begin
          position_next = sat_pos(pos_wide_t'(0) - val_w);
        end
      end
      CMD_SET_MAX: begin
        if (!moving) begin
          max_position_next = sat_pos(pos_w - val_w);
        end
      end
      default: begin
        // Unknown codes leave the state alone.
      end
    endcase

    result.step_level   = moving_next && high_phase_next;
    result.dir_level    = direction_next;
    result.moving       = moving_next;
    result.position     = position_next;
    result.max_position = max_position_next;
    result.event_res    = event_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      max_position <= '0;
      moving       <= 1'b0;
      direction    <= 1'b0;
      pulses_left  <= '0;
      half_period  <= START_PERIOD_RESET;
      ramp_count   <= '0;
      high_phase   <= 1'b0;
      time_left    <= '0;
    end else if (fire) begin
      position     <= position_next;
      max_position <= max_position_next;
      moving       <= moving_next;
      direction    <= direction_next;
      pulses_left  <= pulses_left_next;
      half_period  <= half_period_next;
      ramp_count   <= ramp_count_next;
      high_phase   <= high_phase_next;
      time_left    <= time_left_next;
    end
  end

  a_moving_has_pulses: assert property (@(posedge clk) disable iff (rst)
    moving |-> pulses_left != '0)
    else $error("move in progress with no pulses left");

  a_idle_is_quiet: assert property (@(posedge clk) disable iff (rst)
    !moving |-> (time_left == '0) && !high_phase)
    else $error("idle block still has a phase running");

  a_period_nonzero: assert property (@(posedge clk) disable iff (rst)
    half_period != '0)
    else $error("half-period reached zero");

  a_time_within_period: assert property (@(posedge clk) disable iff (rst)
    time_left <= half_period)
    else $error("phase time exceeds the half-period");

endmodule

// ===== sv/stepper_move_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// stepper_move_pulse_generator: step and direction pulses with a linear ramp
// Input register, single-pass state update and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item is either a 1 us timer tick or a command (move, stop,
//   set home, set max). Every accepted item produces exactly one result item
//   carrying the step and direction pin levels, the moving flag, the current
//   and maximum positions and an event code (move done or target rejected).
//   Both channels use valid/ready; an item moves when valid and ready are
//   high at a rising clock edge.
//   An item accepted at a rising edge sits in the input register, is processed
//   by the core and lands in the result register once that register is free.
//   Throughput is one item per cycle while the receiver keeps taking results;
//   the input register and the result register advance together, so the block
//   keeps taking items while a result is being handed over.
//   When the receiver stalls, the result register holds its item and the
//   input register fills; once both are full in_ready drops until out_ready
//   returns. No item is dropped or repeated.
//   Reset (rst, synchronous) clears the move state, sets the positions to
//   zero, loads the ramp registers with their defaults and empties both
//   pipeline registers. The user must write the ramp registers through wr_en,
//   wr_index and wr_data only while the block is idle; the block has no check for it.
// ----------------------------------------------------------------------------
module stepper_move_pulse_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  smpg_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output smpg_pkg::out_item_t                 out_item,
  input  logic                                wr_en,
  input  logic [smpg_pkg::CFG_IDX_BITS-1:0]   wr_index,
  input  logic [smpg_pkg::CFG_DATA_BITS-1:0]  wr_data
);
  import smpg_pkg::*;

  cfg_t      cfg;
  in_item_t  stage_item;
  logic      stage_valid;
  logic      out_free;
  logic      fire;
  out_item_t result;

  // The result register can take a new item when it is empty or being drained.
  assign out_free = !out_valid || out_ready;
  // The input register can take an item when it is empty or passing its item on.
  assign in_ready = !stage_valid || out_free;
  // The held item is processed, and the state updated, exactly once.
  assign fire     = stage_valid && out_free;

  smpg_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  smpg_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (stage_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= stage_valid;
      end
    end
  end

  // Payload registers carry no reset; the valid flags qualify them.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_item;
    end
    if (fire) begin
      out_item <= result;
    end
  end

endmodule
